// ===== hdl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by the controller and the datapath.
package rau_pkg;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_SIMP = 3'd4;

    localparam logic [1:0] MSEL_P0 = 2'd0;
    localparam logic [1:0] MSEL_P1 = 2'd1;
    localparam logic [1:0] MSEL_P2 = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       gcd_start;
        logic       div_start;
        logic       div_sel;
        logic       mul_go;
        logic [1:0] mul_sel;
        logic       fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       an_zero;
        logic       ad_zero;
        logic       bd_zero;
        logic       gcd_busy;
        logic       div_busy;
        logic       out_free;
    } t_sts;

endpackage

// ===== hdl/rau_dp.sv =====
// Datapath of the rational arithmetic unit: operand registers, binary gcd,
// serial divider, shared multiplier and result register. Uses rau_pkg.
module rau_dp import rau_pkg::*; #(
    parameter int W = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [63:0] o_res_num,
    output logic [63:0] o_res_den,
    output logic        o_valid_res
);
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W + 1);

    logic [2:0]   r_mode;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] m_an, m_ad, m_bn, m_bd;
    logic         is_simp;

    logic [W-1:0]  r_gx, r_gy;
    logic [KW-1:0] r_gk;
    logic          r_gcd_busy;
    logic [W-1:0]  g_val;

    logic [W:0]    r_dv_rem;
    logic [W-1:0]  r_dv_quo, r_dv_den, r_q0, r_q1;
    logic [CW-1:0] r_dv_cnt;
    logic          r_dv_sel, r_div_busy;
    logic [W:0]    rem_sh;
    logic          dv_ge;
    logic [W-1:0]  quo_nx;

    logic [W-1:0]          mul_a, mul_b;
    logic                  mul_neg;
    logic [2*W-1:0]        prod;
    logic signed [2*W-1:0] prod_s;
    logic signed [2*W-1:0] r_p0, r_p1, r_p2;

    logic signed [63:0] p0_64, p1_64, p2_64, q0_64, q1_64;
    logic signed [64:0] sum65;
    logic signed [63:0] sum_sat;
    logic [63:0]        n_num, n_den;
    logic               n_ok;

    logic        r_out_valid, r_valid_res;
    logic [63:0] r_res_num, r_res_den;

    assign m_an = r_an[W-1] ? (~r_an + W'(1)) : r_an;
    assign m_ad = r_ad[W-1] ? (~r_ad + W'(1)) : r_ad;
    assign m_bn = r_bn[W-1] ? (~r_bn + W'(1)) : r_bn;
    assign m_bd = r_bd[W-1] ? (~r_bd + W'(1)) : r_bd;
    assign is_simp = (r_mode == MODE_SIMP);
    assign g_val   = r_gx << r_gk;

    assign rem_sh = {r_dv_rem[W-1:0], r_dv_quo[W-1]};
    assign dv_ge  = (rem_sh >= {1'b0, r_dv_den});
    assign quo_nx = {r_dv_quo[W-2:0], dv_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_an   <= i_a_num[W-1:0];
            r_ad   <= i_a_den[W-1:0];
            r_bn   <= i_b_num[W-1:0];
            r_bd   <= i_b_den[W-1:0];
        end
    end

    // binary gcd: halve evens, subtract odds, stop when equal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcd_busy <= 1'b0;
        end else if (i_cmd.gcd_start) begin
            r_gx       <= is_simp ? m_an : m_ad;
            r_gy       <= is_simp ? m_ad : m_bd;
            r_gk       <= '0;
            r_gcd_busy <= 1'b1;
        end else if (r_gcd_busy) begin
            if (r_gx == r_gy) begin
                r_gcd_busy <= 1'b0;
            end else if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + KW'(1);
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx > r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dv_rem   <= '0;
            r_dv_den   <= g_val;
            r_dv_cnt   <= '0;
            r_dv_sel   <= i_cmd.div_sel;
            r_div_busy <= 1'b1;
            if (i_cmd.div_sel) begin
                r_dv_quo <= is_simp ? m_ad : m_bd;
            end else begin
                r_dv_quo <= is_simp ? m_an : m_ad;
            end
        end else if (r_div_busy) begin
            r_dv_rem <= dv_ge ? (rem_sh - {1'b0, r_dv_den}) : rem_sh;
            r_dv_quo <= quo_nx;
            r_dv_cnt <= r_dv_cnt + CW'(1);
            if (r_dv_cnt == CW'(W - 1)) begin
                r_div_busy <= 1'b0;
                if (r_dv_sel) begin
                    r_q1 <= quo_nx;
                end else begin
                    r_q0 <= quo_nx;
                end
            end
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a   = m_an;
        mul_b   = m_bn;
        mul_neg = r_an[W-1] ^ r_bn[W-1];
        if (r_mode == MODE_ADD || r_mode == MODE_SUB) begin
            case (i_cmd.mul_sel)
                MSEL_P0: begin
                    mul_a   = m_an;
                    mul_b   = r_q1;
                    mul_neg = r_an[W-1] ^ r_ad[W-1];
                end
                MSEL_P1: begin
                    mul_a   = m_bn;
                    mul_b   = r_q0;
                    mul_neg = r_bn[W-1] ^ r_bd[W-1] ^ (r_mode == MODE_SUB);
                end
                default: begin
                    mul_a   = r_q0;
                    mul_b   = m_bd;
                    mul_neg = 1'b0;
                end
            endcase
        end else if (r_mode == MODE_MUL) begin
            if (i_cmd.mul_sel != MSEL_P0) begin
                mul_a   = m_ad;
                mul_b   = m_bd;
                mul_neg = r_ad[W-1] ^ r_bd[W-1];
            end
        end else begin
            if (i_cmd.mul_sel == MSEL_P0) begin
                mul_a   = m_an;
                mul_b   = m_bd;
                mul_neg = r_an[W-1] ^ r_bd[W-1];
            end else begin
                mul_a   = m_ad;
                mul_b   = m_bn;
                mul_neg = r_ad[W-1] ^ r_bn[W-1];
            end
        end
    end

    assign prod   = (2*W)'(mul_a) * (2*W)'(mul_b);
    assign prod_s = signed'(mul_neg ? (~prod + (2*W)'(1)) : prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            case (i_cmd.mul_sel)
                MSEL_P0: r_p0 <= prod_s;
                MSEL_P1: r_p1 <= prod_s;
                default: r_p2 <= prod_s;
            endcase
        end
    end

    assign p0_64 = 64'(r_p0);
    assign p1_64 = 64'(r_p1);
    assign p2_64 = 64'(r_p2);
    assign q0_64 = signed'(64'(r_q0));
    assign q1_64 = signed'(64'(r_q1));
    assign sum65 = 65'(p0_64) + 65'(p1_64);

    always_comb begin
        if (sum65[64] != sum65[63]) begin
            sum_sat = sum65[64] ? signed'({1'b1, 63'd0}) : signed'({1'b0, {63{1'b1}}});
        end else begin
            sum_sat = sum65[63:0];
        end
    end

    always_comb begin
        n_num = 64'd0;
        n_den = 64'd0;
        n_ok  = 1'b0;
        if (r_mode > MODE_SIMP) begin
            n_ok = 1'b0;
        end else if (o_sts.ad_zero) begin
            n_num = 64'(signed'(r_an));
            n_den = 64'(signed'(r_ad));
        end else if (is_simp) begin
            n_ok = 1'b1;
            if (o_sts.an_zero) begin
                n_den = 64'd1;
            end else begin
                n_num = (r_an[W-1] ^ r_ad[W-1]) ? -q0_64 : q0_64;
                n_den = q1_64;
            end
        end else if (o_sts.bd_zero) begin
            n_num = 64'(signed'(r_bn));
            n_den = 64'(signed'(r_bd));
        end else if (r_mode == MODE_ADD || r_mode == MODE_SUB) begin
            n_num = sum_sat;
            n_den = p2_64;
            n_ok  = 1'b1;
        end else begin
            n_num = p0_64;
            n_den = p1_64;
            n_ok  = (r_mode == MODE_MUL) || (p1_64 != 64'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res_num   <= n_num;
            r_res_den   <= n_den;
            r_valid_res <= n_ok;
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.an_zero  = (r_an == '0);
    assign o_sts.ad_zero  = (r_ad == '0);
    assign o_sts.bd_zero  = (r_bd == '0);
    assign o_sts.gcd_busy = r_gcd_busy;
    assign o_sts.div_busy = r_div_busy;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_valid_res = r_valid_res;

endmodule

// ===== hdl/rau_ctrl.sv =====
// Controller of the rational arithmetic unit: sequences gcd, division and
// multiply steps of the datapath per mode. Uses rau_pkg.
module rau_ctrl import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_GCD, S_DIV, S_MUL, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic       r_in_ready, n_in_ready;
    logic       r_dsel, n_dsel;
    logic [1:0] r_midx, n_midx;
    logic       two_op_add, early;
    logic [1:0] last_idx;

    assign two_op_add = (i_sts.mode == MODE_ADD) || (i_sts.mode == MODE_SUB);
    assign last_idx   = two_op_add ? MSEL_P2 : MSEL_P1;
    // operand cases that finish without arithmetic
    assign early = (i_sts.mode > MODE_SIMP) || i_sts.ad_zero ||
                   ((i_sts.mode == MODE_SIMP) && i_sts.an_zero) ||
                   ((i_sts.mode != MODE_SIMP) && i_sts.bd_zero);

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        n_dsel     = r_dsel;
        n_midx     = r_midx;
        o_cmd      = '0;
        o_cmd.div_sel = n_dsel;
        o_cmd.mul_sel = r_midx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_in_ready = 1'b0;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_midx = MSEL_P0;
                n_dsel = 1'b0;
                if (early) begin
                    n_state = S_FIN;
                end else if (two_op_add || i_sts.mode == MODE_SIMP) begin
                    o_cmd.gcd_start = 1'b1;
                    n_state = S_GCD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_GCD: begin
                if (!i_sts.gcd_busy) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    if (!r_dsel) begin
                        n_dsel          = 1'b1;
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = 1'b1;
                    end else if (i_sts.mode == MODE_SIMP) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (r_midx == last_idx) begin
                    n_state = S_FIN;
                end else begin
                    n_midx = r_midx + 2'd1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin  = 1'b1;
                    n_in_ready = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_dsel     <= 1'b0;
            r_midx     <= MSEL_P0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
            r_dsel     <= n_dsel;
            r_midx     <= n_midx;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ===== hdl/rational_arith_unit.sv =====
// Rational arithmetic unit: one request in, one rational result out.
// Zero-denominator, zero simplify and unused modes finish without arithmetic; mul/div
// run the multiply steps only; add/sub run the binary gcd loop and two serial divides
// before the multiply steps, and simplify stops after the divides.
// One request at a time; the next is taken once the result is registered.
// Reset: synchronous active-low; clears the controller and output valid.
module rational_arith_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_res_num,
    output logic [63:0] o_res_den,
    output logic        o_valid_res
);
    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rau_dp #(.W(OPERAND_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_valid_res (o_valid_res)
    );

endmodule

// ===== hdl/rau_checker.sv =====
// Port-level checks for rational_arith_unit, attached by bind.
// No package dependencies.
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_res_num,
    input logic [63:0] o_res_den,
    input logic        o_valid_res
);
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("outputs not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while busy");

    a_good_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> o_res_den != 64'd0)
        else $error("valid result with zero denominator");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_res_num) && $stable(o_res_den) &&
            $stable(o_valid_res))
        else $error("stalled result changed");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_res_num   (o_res_num),
    .o_res_den   (o_res_den),
    .o_valid_res (o_valid_res)
);

// ===== verif/rational_arith_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rational_arith_unit: directed and random requests,
// each result checked against an in-bench model. Depends on rau_pkg and the RTL.
module rational_arith_unit_tb import rau_pkg::*; ();

    localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
    localparam int LAT_CYCLES = 4 * 32 + 30;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic        ok;
    } t_ratio;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_mode;
    logic [31:0] i_a_num;
    logic [31:0] i_a_den;
    logic [31:0] i_b_num;
    logic [31:0] i_b_den;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_res_num;
    logic [63:0] o_res_den;
    logic        o_valid_res;

    t_ratio pending_results[$];
    int     error_count = 0;
    int     burst_left = 0;
    int     gap_len = 0;
    int     cycle_cnt = 0;

    rational_arith_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_valid_res (o_valid_res)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic longint sat_sum(longint x, longint y);
        longint max_v, min_v;
        max_v = 64'sh7fff_ffff_ffff_ffff;
        min_v = 64'sh8000_0000_0000_0000;
        if (y > 0 && x > max_v - y) return max_v;
        if (y < 0 && x < min_v - y) return min_v;
        return x + y;
    endfunction

    function automatic t_ratio compute_rational(logic [2:0] mode, logic [31:0] a_n,
                                                logic [31:0] a_d, logic [31:0] b_n,
                                                logic [31:0] b_d);
        longint an, ad, bn, bd, l, ta, tb, g;
        longint unsigned ua, ub;
        t_ratio r;
        an = longint'(signed'(a_n));
        ad = longint'(signed'(a_d));
        bn = longint'(signed'(b_n));
        bd = longint'(signed'(b_d));
        r = '0;
        if (mode >= MODE_FIRST_UNUSED) return r;
        if (ad == 0) begin
            r.num = an; r.den = ad; r.ok = 1'b0;
            return r;
        end
        if (mode == MODE_SIMP) begin
            if (an == 0) begin
                r.num = 64'd0; r.den = 64'd1; r.ok = 1'b1;
                return r;
            end
            if (ad < 0) begin
                an = -an;
                ad = -ad;
            end
            g = longint'(gcd64(magnitude(an), magnitude(ad)));
            r.num = an / g; r.den = ad / g; r.ok = 1'b1;
            return r;
        end
        if (bd == 0) begin
            r.num = bn; r.den = bd; r.ok = 1'b0;
            return r;
        end
        case (mode)
            MODE_ADD, MODE_SUB: begin
                ua = magnitude(ad);
                ub = magnitude(bd);
                l  = longint'((ua / gcd64(ua, ub)) * ub);
                ta = an * (l / ad);
                tb = bn * (l / bd);
                r.num = (mode == MODE_ADD) ? sat_sum(ta, tb) : sat_sum(ta, -tb);
                r.den = l;
                r.ok  = 1'b1;
            end
            MODE_MUL: begin
                r.num = an * bn; r.den = ad * bd; r.ok = 1'b1;
            end
            default: begin
                r.num = an * bd; r.den = ad * bn; r.ok = (ad * bn) != 0;
            end
        endcase
        return r;
    endfunction

    // Drive one request; bursts of back-to-back transfers separated by random gaps, some of them empty.
    task automatic send_request(logic [2:0] mode, logic [31:0] a_n, logic [31:0] a_d,
                                logic [31:0] b_n, logic [31:0] b_d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap_len    = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            if (gap_len > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_a_num    <= a_n;
        i_a_den    <= a_d;
        i_b_num    <= b_n;
        i_b_den    <= b_d;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(compute_rational(mode, a_n, a_d, b_n, b_d));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
            4:          return 32'($signed($urandom_range(2000)) - 1000);
            5: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_add_sub();
        send_request(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(MODE_ADD, -32'sd5, 32'd6, 32'd7, -32'sd4);
        send_request(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_request(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001);
        send_request(MODE_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff);
    endtask

    task automatic test_mul_div();
        send_request(MODE_MUL, 32'd3, 32'd4, -32'sd5, 32'd7);
        send_request(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(MODE_DIV, 32'd3, 32'd4, 32'd5, -32'sd7);
        send_request(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        // divide by a zero rational
        send_request(MODE_DIV, 32'd9, 32'd2, 32'd0, 32'd5);
    endtask

    task automatic test_simplify();
        send_request(MODE_SIMP, 32'd6, -32'sd4, 32'hffff_ffff, 32'hffff_ffff);
        send_request(MODE_SIMP, 32'd0, 32'd5, 32'd0, 32'd0);
        send_request(MODE_SIMP, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_request(MODE_SIMP, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
        send_request(MODE_SIMP, 32'h7fff_ffff, 32'h7fff_fffe, 32'd0, 32'd0);
    endtask

    task automatic test_zero_den_and_unused();
        send_request(MODE_ADD, 32'd7, 32'd0, 32'd1, 32'd0);
        send_request(MODE_MUL, 32'd7, 32'd3, 32'h8000_0000, 32'd0);
        send_request(MODE_SIMP, 32'h8000_0000, 32'd0, 32'd1, 32'd1);
        send_request(MODE_DIV, 32'd1, 32'd1, 32'd2, 32'd0);
        for (int k = 0; k < 3; k++)
            send_request(MODE_FIRST_UNUSED + 3'(k), 32'hffff_ffff, 32'd1, 32'd2, 32'd3);
    endtask

    task automatic test_random(int count);
        logic [2:0] mode;
        for (int n = 0; n < count; n++) begin
            mode = ($urandom_range(40) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4));
            send_request(mode, rand_operand(), rand_operand(), rand_operand(),
                         rand_operand());
        end
    endtask

    // Receiver: alternate stall-free stretches with random stalls.
    always @(negedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((cycle_cnt / 500) % 3 == 0)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(3) != 0);
    end

    always @(posedge i_clk) begin
        t_ratio want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result num=%h den=%h ok=%b", $time,
                         o_res_num, o_res_den, o_valid_res);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res_num !== want.num) begin
                    $display("%0t: res_num expected %h actual %h", $time, want.num, o_res_num);
                    error_count++;
                end
                if (o_res_den !== want.den) begin
                    $display("%0t: res_den expected %h actual %h", $time, want.den, o_res_den);
                    error_count++;
                end
                if (o_valid_res !== want.ok) begin
                    $display("%0t: valid_res expected %b actual %b", $time, want.ok,
                             o_valid_res);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = MODE_ADD;
        i_a_num    = '0;
        i_a_den    = '0;
        i_b_num    = '0;
        i_b_den    = '0;
        i_out_ready = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_add_sub();
        test_mul_div();
        test_simplify();
        test_zero_den_and_unused();
        test_random(1950);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
